// ===== hw/rtl/fcd_pkg.sv =====
package fcd_pkg;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_VIDEO   = 3'd0;
    localparam t_mode MODE_22_EVEN = 3'd1;
    localparam t_mode MODE_22_ODD  = 3'd2;
    localparam t_mode MODE_32_P0   = 3'd3;
    localparam t_mode MODE_32_P1   = 3'd4;
    localparam t_mode MODE_32_P2   = 3'd5;
    localparam t_mode MODE_32_P3   = 3'd6;
    localparam t_mode MODE_32_P4   = 3'd7;

    typedef enum logic [1:0] {
        CLASS_MOTION = 2'd0,
        CLASS_STILL  = 2'd1,
        CLASS_AMBIG  = 2'd2
    } t_frame_class;

    localparam int THR_W     = 14;
    localparam int REPEAT_W  = 5;
    localparam int DIFF_W    = 32;
    localparam int PHASE_W   = 3;
    localparam int STILL_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STANDARD   = 2'd3;

    localparam logic [THR_W-1:0]    RST_STILL_THR  = 14'd30;
    localparam logic [THR_W-1:0]    RST_MOTION_THR = 14'd200;
    localparam logic [REPEAT_W-1:0] RST_REPEAT     = 5'd4;

    localparam logic [STILL_W-1:0]  STILL_MAX = 8'd255;
    localparam logic [REPEAT_W-1:0] MATCH_MAX = 5'd31;

    typedef struct packed {
        logic                 command;
        logic [DIFF_W-1:0]    frame_difference;
        logic [PHASE_W-1:0]   cadence_phase;
    } t_fcd_in;

    typedef struct packed {
        logic         film_locked;
        t_mode        locked_mode;
        t_mode        candidate_mode;
        t_frame_class frame_class;
        logic         dropped_to_video;
    } t_fcd_out;

    typedef struct packed {
        logic [REPEAT_W-1:0] repeat_needed;
        logic                ntsc;
    } t_fcd_cfg;

    // 3:2 phase guess after a run of one or of two still frames
    localparam t_mode RUN1_GUESS [5] = '{MODE_32_P0, MODE_32_P4, MODE_32_P3,
                                         MODE_32_P2, MODE_32_P1};
    localparam t_mode RUN2_GUESS [5] = '{MODE_32_P3, MODE_32_P2, MODE_32_P1,
                                         MODE_32_P0, MODE_32_P4};

    function automatic logic expects_change(input t_mode mode,
                                            input logic [PHASE_W-1:0] phase);
        logic res;
        case (mode)
            MODE_22_EVEN: res = ~phase[0];
            MODE_22_ODD:  res = phase[0];
            MODE_32_P0:   res = phase inside {3'd0, 3'd3};
            MODE_32_P1:   res = phase inside {3'd4, 3'd2};
            MODE_32_P2:   res = phase inside {3'd3, 3'd1};
            MODE_32_P3:   res = phase inside {3'd2, 3'd0};
            MODE_32_P4:   res = phase inside {3'd1, 3'd4};
            default:      res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic t_mode guess_mode(input logic [PHASE_W-1:0] phase,
                                         input logic ntsc,
                                         input logic [STILL_W-1:0] still_run);
        t_mode res;
        res = MODE_VIDEO;
        if (!ntsc) begin
            if (still_run == 8'd1 && phase < 3'd4) begin
                res = phase[0] ? MODE_22_ODD : MODE_22_EVEN;
            end
        end else if (phase < 3'd5) begin
            if (still_run == 8'd1) begin
                res = RUN1_GUESS[phase];
            end else if (still_run == 8'd2) begin
                res = RUN2_GUESS[phase];
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/fcd_frame_if.sv =====
interface fcd_frame_if import fcd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_fcd_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fcd_result_if.sv =====
interface fcd_result_if import fcd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_fcd_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fcd_classify.sv =====
module fcd_classify import fcd_pkg::*; (
    input  logic [DIFF_W-1:0] i_diff,
    input  logic [THR_W-1:0]  i_still_thr,
    input  logic [THR_W-1:0]  i_motion_thr,
    output t_frame_class      o_class
);

    logic [DIFF_W-1:0] still_ext;
    logic [DIFF_W-1:0] motion_ext;

    assign still_ext  = {{(DIFF_W-THR_W){1'b0}}, i_still_thr};
    assign motion_ext = {{(DIFF_W-THR_W){1'b0}}, i_motion_thr};

    // motion wins when the thresholds cross
    always_comb begin
        if (i_diff > motion_ext) begin
            o_class = CLASS_MOTION;
        end else if (i_diff < still_ext) begin
            o_class = CLASS_STILL;
        end else begin
            o_class = CLASS_AMBIG;
        end
    end

endmodule

// ===== hw/rtl/fcd_tracker.sv =====
module fcd_tracker import fcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_command,
    input  t_frame_class       i_class,
    input  logic [PHASE_W-1:0] i_phase,
    input  t_fcd_cfg           i_cfg,
    output t_fcd_out           o_result
);

    logic [STILL_W-1:0]  r_still_run,  n_still_run;
    logic [REPEAT_W-1:0] r_match,      n_match;
    t_mode               r_detect,     n_detect;
    logic                r_film,       n_film;
    t_mode               r_active,     n_active;

    logic                dropped;
    t_mode               guess;
    logic [REPEAT_W-1:0] match_inc;

    assign guess     = guess_mode(i_phase, i_cfg.ntsc, r_still_run);
    assign match_inc = (r_match < MATCH_MAX) ? r_match + 5'd1 : r_match;

    always_comb begin
        n_still_run = r_still_run;
        n_match     = r_match;
        n_detect    = r_detect;
        n_film      = r_film;
        n_active    = r_active;
        dropped     = 1'b0;
        if (i_command) begin
            n_still_run = '0;
            n_match     = '0;
            n_detect    = MODE_VIDEO;
        end else begin
            case (i_class)
                CLASS_MOTION: begin
                    if (r_film) begin
                        // motion where the locked cadence repeats a picture
                        if (!expects_change(r_active, i_phase)) begin
                            n_film   = 1'b0;
                            n_active = MODE_VIDEO;
                            n_detect = MODE_VIDEO;
                            dropped  = 1'b1;
                        end
                    end else if (guess == MODE_VIDEO) begin
                        n_match  = '0;
                        n_detect = MODE_VIDEO;
                    end else if (guess != r_detect) begin
                        n_match  = '0;
                        n_detect = guess;
                    end else begin
                        n_match = match_inc;
                        if (match_inc >= i_cfg.repeat_needed &&
                            (!i_cfg.ntsc || r_still_run == 8'd2)) begin
                            n_film   = 1'b1;
                            n_active = r_detect;
                        end
                    end
                    n_still_run = '0;
                end
                CLASS_STILL: begin
                    if (!r_film) begin
                        if (r_still_run < STILL_MAX) begin
                            n_still_run = r_still_run + 8'd1;
                        end
                        if (expects_change(r_detect, i_phase)) begin
                            n_match  = '0;
                            n_detect = MODE_VIDEO;
                        end
                    end
                end
                default: begin
                    if (!r_film) begin
                        n_still_run = '0;
                        n_match     = '0;
                        n_detect    = MODE_VIDEO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still_run <= '0;
            r_match     <= '0;
            r_detect    <= MODE_VIDEO;
            r_film      <= 1'b0;
            r_active    <= MODE_VIDEO;
        end else if (i_step) begin
            r_still_run <= n_still_run;
            r_match     <= n_match;
            r_detect    <= n_detect;
            r_film      <= n_film;
            r_active    <= n_active;
        end
    end

    always_comb begin
        o_result.film_locked      = n_film;
        o_result.locked_mode      = n_active;
        o_result.candidate_mode   = n_detect;
        o_result.frame_class      = i_command ? CLASS_MOTION : i_class;
        o_result.dropped_to_video = dropped;
    end

endmodule

// ===== hw/rtl/film_cadence_detector_unit.sv =====
// Film cadence detector: one frame measurement in, one result out, at a sustained
// rate of one transfer per clock while the result side keeps accepting. A frame is
// captured in the input register, then classified and run through the cadence
// tracker once the output register is free, and its result lands in the output
// register. The rate is set by the tracker's state update, which is registered as
// each frame advances so that the next frame sees it. The input stays ready while a
// result waits as long as the input register is empty or the output register will
// be freed. Write the configuration registers only while no frame is in flight.
module film_cadence_detector_unit import fcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data,
    fcd_frame_if.sink            i_frame,
    fcd_result_if.source         o_result
);

    logic [THR_W-1:0]    r_still_thr;
    logic [THR_W-1:0]    r_motion_thr;
    logic [REPEAT_W-1:0] r_repeat;
    logic                r_ntsc;

    logic                r_in_valid;
    t_fcd_in             r_in;
    logic                r_out_valid;
    t_fcd_out            r_out;

    logic                advance;
    t_frame_class        frame_class;
    t_fcd_cfg            cfg;
    t_fcd_out            result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still_thr  <= RST_STILL_THR;
            r_motion_thr <= RST_MOTION_THR;
            r_repeat     <= RST_REPEAT;
            r_ntsc       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STILL_THR:  r_still_thr  <= i_cfg_data;
                CFG_MOTION_THR: r_motion_thr <= i_cfg_data;
                CFG_REPEAT:     r_repeat     <= i_cfg_data[REPEAT_W-1:0];
                CFG_STANDARD:   r_ntsc       <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // advance the captured frame once the output register is free
    assign advance       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in <= i_frame.data;
        end
    end

    assign cfg.repeat_needed = r_repeat;
    assign cfg.ntsc          = r_ntsc;

    fcd_classify u_classify (
        .i_diff       (r_in.frame_difference),
        .i_still_thr  (r_still_thr),
        .i_motion_thr (r_motion_thr),
        .o_class      (frame_class)
    );

    fcd_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_command (r_in.command),
        .i_class   (frame_class),
        .i_phase   (r_in.cadence_phase),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

// ===== tb/sv/film_cadence_detector_unit_test.sv =====
module film_cadence_detector_unit_test;
    import fcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;
    localparam logic STD_PAL     = 1'b0;
    localparam logic STD_NTSC    = 1'b1;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0]     cfg_data = '0;
    logic                 tx_valid = 1'b0;
    t_fcd_in              tx_data = '0;
    logic                 rx_ready = 1'b0;

    fcd_frame_if  frame_bus ();
    fcd_result_if result_bus ();

    assign frame_bus.valid  = tx_valid;
    assign frame_bus.data   = tx_data;
    assign result_bus.ready = rx_ready;

    film_cadence_detector_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_frame     (frame_bus),
        .o_result    (result_bus)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // shadow copy of the configuration
    logic [THR_W-1:0]    cfg_still  = RST_STILL_THR;
    logic [THR_W-1:0]    cfg_motion = RST_MOTION_THR;
    logic [REPEAT_W-1:0] cfg_repeat = RST_REPEAT;
    logic                cfg_ntsc   = STD_PAL;

    // shadow copy of the cadence tracker
    logic [STILL_W-1:0]  still_run  = '0;
    logic [REPEAT_W-1:0] match_run  = '0;
    t_mode               hunt_mode  = MODE_VIDEO;
    logic                film_on    = 1'b0;
    t_mode               film_mode  = MODE_VIDEO;

    t_fcd_in  frame_q[$];
    t_fcd_out expected_q[$];

    int frames_queued   = 0;
    int frames_accepted = 0;
    int results_seen    = 0;
    int mismatches      = 0;

    int tx_gap = 0, tx_quiet = 0;
    int rx_gap = 0, rx_quiet = 0, hold_left = 0;
    int stuck_cycles = 0;

    t_mode src_mode = MODE_22_EVEN;
    int    src_phase = 0;
    int    src_period = 4;

    function automatic logic wants_new_picture(input t_mode mode,
                                               input logic [PHASE_W-1:0] ph);
        int slot;
        slot = (int'(ph) + int'(mode) - int'(MODE_32_P0)) % 5;
        if (mode == MODE_22_EVEN) return !ph[0];
        if (mode == MODE_22_ODD) return ph[0];
        // 3:2 cadence: a new picture where phase plus offset lands on 0 or 3
        if (mode >= MODE_32_P0) return (ph < 3'd5) && (slot == 0 || slot == 3);
        return 1'b1;
    endfunction

    function automatic t_mode cadence_guess(input logic [PHASE_W-1:0] ph);
        t_mode res;
        res = MODE_VIDEO;
        if (!cfg_ntsc) begin
            if (still_run == 8'd1 && ph < 3'd4) res = ph[0] ? MODE_22_ODD : MODE_22_EVEN;
        end else if (ph < 3'd5 && (still_run == 8'd1 || still_run == 8'd2)) begin
            // offset steps back by one for each step of phase
            res = t_mode'(int'(MODE_32_P0) + ((still_run == 8'd1 ? 5 : 8) - int'(ph)) % 5);
        end
        return res;
    endfunction

    function automatic t_fcd_out track_frame(input t_fcd_in f);
        t_fcd_out     r;
        t_mode        guess;
        t_frame_class cls;
        logic         drop;
        cls  = CLASS_MOTION;
        drop = 1'b0;
        if (f.command == CMD_CLEAR) begin
            still_run = '0;
            match_run = '0;
            hunt_mode = MODE_VIDEO;
        end else if (f.frame_difference > DIFF_W'(cfg_motion)) begin
            if (film_on) begin
                if (!wants_new_picture(film_mode, f.cadence_phase)) begin
                    film_on   = 1'b0;
                    film_mode = MODE_VIDEO;
                    hunt_mode = MODE_VIDEO;
                    drop      = 1'b1;
                end
            end else begin
                guess = cadence_guess(f.cadence_phase);
                if (guess == MODE_VIDEO || guess != hunt_mode) begin
                    match_run = '0;
                    hunt_mode = guess;
                end else begin
                    if (match_run != MATCH_MAX) match_run++;
                    if (match_run >= cfg_repeat && (!cfg_ntsc || still_run == 8'd2)) begin
                        film_on   = 1'b1;
                        film_mode = hunt_mode;
                    end
                end
            end
            still_run = '0;
        end else if (f.frame_difference < DIFF_W'(cfg_still)) begin
            cls = CLASS_STILL;
            if (!film_on) begin
                if (still_run != STILL_MAX) still_run++;
                if (wants_new_picture(hunt_mode, f.cadence_phase)) begin
                    match_run = '0;
                    hunt_mode = MODE_VIDEO;
                end
            end
        end else begin
            cls = CLASS_AMBIG;
            if (!film_on) begin
                still_run = '0;
                match_run = '0;
                hunt_mode = MODE_VIDEO;
            end
        end
        r.film_locked      = film_on;
        r.locked_mode      = film_mode;
        r.candidate_mode   = hunt_mode;
        r.frame_class      = cls;
        r.dropped_to_video = drop;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DIFF_W-1:0] motion_diff();
        if ($urandom_range(0, 9) == 0) return $urandom | 32'h8000_0000;
        return DIFF_W'(cfg_motion) + 32'd1 + $urandom_range(0, 3000);
    endfunction

    function automatic logic [DIFF_W-1:0] still_diff();
        int unsigned lim;
        lim = 32'(cfg_still);
        // crossed thresholds: stay at or below motion so the frame is still
        if (cfg_still > cfg_motion) lim = 32'(cfg_motion) + 1;
        if (lim == 0) return '0;
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic logic [DIFF_W-1:0] ambig_diff();
        if (cfg_still <= cfg_motion) return $urandom_range(cfg_still, cfg_motion);
        return DIFF_W'(cfg_motion);
    endfunction

    task automatic push_frame(input logic cmd, input logic [DIFF_W-1:0] diff,
                              input logic [PHASE_W-1:0] ph);
        t_fcd_in f;
        f.command          = cmd;
        f.frame_difference = diff;
        f.cadence_phase    = ph;
        frame_q.push_back(f);
        frames_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_STILL_THR:  cfg_still  = val;
            CFG_MOTION_THR: cfg_motion = val;
            CFG_REPEAT:     cfg_repeat = val[REPEAT_W-1:0];
            CFG_STANDARD:   cfg_ntsc   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned still_thr, input int unsigned motion_thr,
                              input int unsigned repeats, input logic standard);
        write_reg(CFG_STILL_THR, THR_W'(still_thr));
        write_reg(CFG_MOTION_THR, THR_W'(motion_thr));
        write_reg(CFG_REPEAT, THR_W'(repeats));
        write_reg(CFG_STANDARD, THR_W'(standard));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (frames_accepted != frames_queued || expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic pick_source();
        if ($urandom_range(0, 4) == 0) begin
            src_mode = t_mode'($urandom_range(1, 7));
        end else if (cfg_ntsc) begin
            src_mode = t_mode'(int'(MODE_32_P0) + $urandom_range(0, 4));
        end else begin
            src_mode = $urandom_range(0, 1) ? MODE_22_ODD : MODE_22_EVEN;
        end
        src_period = (src_mode >= MODE_32_P0) ? 5 : 4;
        src_phase  = $urandom_range(0, src_period - 1);
    endtask

    // mostly clean film cadence with random content, some noise and clears
    task automatic queue_random(input int count);
        int r;
        logic [DIFF_W-1:0] d;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (i == 0 || r < 2) pick_source();
            if (r < 4) begin
                push_frame(CMD_CLEAR, $urandom, PHASE_W'($urandom_range(0, 7)));
            end else if (r < 10) begin
                case ($urandom_range(0, 3))
                    0: d = $urandom;
                    1: d = '1;
                    2: d = '0;
                    default: d = $urandom_range(0, 16383);
                endcase
                push_frame(CMD_MEASURE, d, PHASE_W'($urandom_range(0, 7)));
            end else if (r < 13) begin
                push_frame(CMD_MEASURE, ambig_diff(), PHASE_W'(src_phase));
            end else begin
                d = wants_new_picture(src_mode, PHASE_W'(src_phase)) ? motion_diff()
                                                                     : still_diff();
                push_frame(CMD_MEASURE, d, PHASE_W'(src_phase));
                src_phase = (src_phase + 1) % src_period;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // frame driver
    always @(posedge clk) begin
        if (!rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_valid && frame_bus.ready) begin
                expected_q.push_back(track_frame(tx_data));
                frames_accepted++;
                if (tx_quiet != 0) begin
                    tx_quiet--;
                end else begin
                    tx_gap = idle_len();
                    if ($urandom_range(0, 39) == 0) tx_quiet = 50;
                end
            end
            if (!tx_valid || frame_bus.ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    tx_valid <= 1'b0;
                end else if (frame_q.size() != 0) begin
                    tx_data  <= frame_q.pop_front();
                    tx_valid <= 1'b1;
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_fcd_out want;
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (result_bus.valid && rx_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("result transfer with no frame outstanding");
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("film_locked", want.film_locked, result_bus.data.film_locked);
                    check_field("locked_mode", want.locked_mode, result_bus.data.locked_mode);
                    check_field("candidate_mode", want.candidate_mode,
                                result_bus.data.candidate_mode);
                    check_field("frame_class", int'(want.frame_class),
                                int'(result_bus.data.frame_class));
                    check_field("dropped_to_video", want.dropped_to_video,
                                result_bus.data.dropped_to_video);
                end
                // hold off long enough for the block to back up into its input
                if (results_seen == 150 || results_seen == 250) hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rx_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
                if (rx_quiet != 0) begin
                    rx_quiet--;
                end else begin
                    rx_gap = idle_len();
                    if ($urandom_range(0, 39) == 0) rx_quiet = 50;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (tx_valid && frame_bus.ready) || (result_bus.valid && rx_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // PAL: lock on the first confirmation, drop, out-of-range phase
        set_config(30, 200, 0, STD_PAL);
        push_frame(CMD_CLEAR, '1, 3'd7);
        push_frame(CMD_MEASURE, 32'd0, 3'd1);
        push_frame(CMD_MEASURE, 32'd201, 3'd0);
        push_frame(CMD_MEASURE, 32'd29, 3'd1);
        push_frame(CMD_MEASURE, '1, 3'd2);
        push_frame(CMD_MEASURE, 32'd0, 3'd3);
        push_frame(CMD_MEASURE, 32'd30, 3'd0);
        push_frame(CMD_MEASURE, 32'd200, 3'd1);
        push_frame(CMD_CLEAR, 32'd0, 3'd0);
        push_frame(CMD_MEASURE, 32'd5000, 3'd0);
        push_frame(CMD_MEASURE, 32'd5000, 3'd7);
        push_frame(CMD_MEASURE, 32'd3, 3'd4);
        push_frame(CMD_MEASURE, 32'd900, 3'd4);
        push_frame(CMD_MEASURE, 32'd3, 3'd0);
        push_frame(CMD_MEASURE, 32'd900, 3'd1);
        push_frame(CMD_MEASURE, 32'd3, 3'd7);
        wait_drained();

        // NTSC: lock needs a run of two stills, then drop and phase past 4
        set_config(30, 200, 0, STD_NTSC);
        push_frame(CMD_MEASURE, 32'd100, 3'd0);
        push_frame(CMD_MEASURE, 32'd0, 3'd1);
        push_frame(CMD_MEASURE, 32'd10, 3'd2);
        push_frame(CMD_MEASURE, 32'd500, 3'd3);
        push_frame(CMD_MEASURE, 32'd0, 3'd4);
        push_frame(CMD_MEASURE, 32'd500, 3'd0);
        push_frame(CMD_MEASURE, 32'd0, 3'd1);
        push_frame(CMD_MEASURE, 32'd0, 3'd2);
        push_frame(CMD_MEASURE, 32'd500, 3'd3);
        push_frame(CMD_MEASURE, 32'd500, 3'd5);
        push_frame(CMD_MEASURE, 32'd0, 3'd0);
        push_frame(CMD_MEASURE, 32'd500, 3'd6);
        wait_drained();

        set_config(RST_STILL_THR, RST_MOTION_THR, RST_REPEAT, STD_PAL);
        queue_random(40);
        wait_drained();

        set_config(50, 10000, 20, STD_NTSC);
        queue_random(40);
        wait_drained();

        set_config(10000, 0, 1, STD_PAL);
        queue_random(20);
        wait_drained();

        // long still run: the run counter must stick at its ceiling
        set_config(1, 1, 2, STD_NTSC);
        repeat (257) push_frame(CMD_MEASURE, 32'd0, PHASE_W'($urandom_range(0, 4)));
        push_frame(CMD_MEASURE, '1, 3'd0);
        queue_random(20);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("Checked %0d frames: PAL and NTSC cadences, lock, drop and clear commands,",
                 frames_accepted);
        $display("extreme and crossed thresholds, repeat counts 0 to 20 and a long still run");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
